// ===== hw/rtl/nrvp_pkg.sv =====
`default_nettype none

package nrvp_pkg;

    // Field and register widths.
    localparam int unsigned ByteW    = 8;
    localparam int unsigned GroupW   = 7;
    localparam int unsigned StatusW  = 3;
    localparam int unsigned FreqW    = 15;
    localparam int unsigned FreqAccW = FreqW + GroupW;
    localparam int unsigned TokenW   = 32;
    localparam int unsigned CountW   = 4;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 32;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_TOKENS_PER_RECORD = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_VOCAB_SIZE        = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_FREQ          = 2'd2;

    // Configuration reset values.
    localparam logic [CountW-1:0] RST_TOKENS_PER_RECORD = 4'd1;
    localparam logic [TokenW-1:0] RST_VOCAB_SIZE        = 32'hFFFF_FFFF;
    localparam logic [FreqW-1:0]  RST_MAX_FREQ          = 15'h7FFF;

    // Result status codes.
    typedef enum logic [StatusW-1:0] {
        ST_BUSY      = 3'd0,
        ST_DONE      = 3'd1,
        ST_BIGFREQ   = 3'd2,
        ST_BADTOKEN  = 3'd3,
        ST_END_CLEAN = 3'd4,
        ST_END_PART  = 3'd5,
        ST_HALTED    = 3'd6
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ngram_record_varint_parser.sv =====
// N-gram record varint parser.
// Input channel (s_valid/s_ready) carries one stream word per handshake: a record
// byte on s_data_byte, or an end-of-stream marker when s_stream_end is high.
// Records are one frequency followed by tokens_per_record token ids, each a
// big-endian varint of 7-bit groups. Every accepted word yields exactly one
// result word on the m_ channel: status, the frequency on record completion,
// and the byte passed through.
// Results are registered: a word accepted at a clock edge is captured into the
// output register at that edge. Throughput is one word per cycle while the
// receiver takes results, set by the single output register; s_ready stays
// high while the output register is empty or being drained. When the receiver
// stalls, the result holds and s_ready drops until it is taken. Configuration
// writes (cfg_wr_en, cfg_index, cfg_wdata) are expected only while the block is idle.
// Reset clears the record state and the halt flag, empties the output register
// and restores the register defaults. After an error every word answers halted
// until the next reset.
`default_nettype none

module ngram_record_varint_parser (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [nrvp_pkg::ByteW-1:0]          s_data_byte,
    input  wire                                 s_stream_end,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [nrvp_pkg::StatusW-1:0]        m_status,
    output logic [nrvp_pkg::FreqW-1:0]          m_freq,
    output logic [nrvp_pkg::ByteW-1:0]          m_byte_out,
    input  wire                                 cfg_wr_en,
    input  wire  [nrvp_pkg::CfgIdxW-1:0]        cfg_index,
    input  wire  [nrvp_pkg::CfgDataW-1:0]       cfg_wdata
);
    import nrvp_pkg::*;

    logic [CountW-1:0]      tokens_per_record_reg;
    logic [TokenW-1:0]      vocab_size_reg;
    logic [FreqW-1:0]       max_freq_reg;

    logic                   in_token_phase_reg, in_token_phase_next;
    logic [FreqW-1:0]       freq_accum_reg, freq_accum_next;
    logic [TokenW-1:0]      token_accum_reg, token_accum_next;
    logic [CountW-1:0]      tokens_seen_reg, tokens_seen_next;
    logic                   mid_record_reg, mid_record_next;
    logic                   halted_reg, halted_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic [FreqW-1:0]       freq_reg, freq_next;
    logic [ByteW-1:0]       byte_reg, byte_next;

    logic                   in_acc;
    logic [GroupW-1:0]      low;
    logic                   last;
    logic [FreqAccW-1:0]    freq_shift;
    logic [TokenW+GroupW-1:0] tok_shift;
    logic [TokenW-1:0]      tok_sat;
    logic [CountW-1:0]      tokens_inc;

    // Handshake: the output register frees up when empty or being read.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_acc  = s_valid && s_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tokens_per_record_reg <= RST_TOKENS_PER_RECORD;
            vocab_size_reg        <= RST_VOCAB_SIZE;
            max_freq_reg          <= RST_MAX_FREQ;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TOKENS_PER_RECORD: tokens_per_record_reg <= cfg_wdata[CountW-1:0];
                CFG_VOCAB_SIZE:        vocab_size_reg        <= cfg_wdata[TokenW-1:0];
                CFG_MAX_FREQ:          max_freq_reg          <= cfg_wdata[FreqW-1:0];
                default: ;
            endcase
        end
    end

    // Shift in one 7-bit group; the token value saturates at all ones.
    assign low        = s_data_byte[GroupW-1:0];
    assign last       = !s_data_byte[ByteW-1];
    assign freq_shift = {freq_accum_reg, low};
    assign tok_shift  = {token_accum_reg, low};
    assign tok_sat    = (|tok_shift[TokenW+GroupW-1:TokenW]) ? {TokenW{1'b1}}
                                                             : tok_shift[TokenW-1:0];
    assign tokens_inc = tokens_seen_reg + CountW'(1);

    // Parse step for the word at the input.
    always_comb begin
        in_token_phase_next = in_token_phase_reg;
        freq_accum_next     = freq_accum_reg;
        token_accum_next    = token_accum_reg;
        tokens_seen_next    = tokens_seen_reg;
        mid_record_next     = mid_record_reg;
        halted_next         = halted_reg;
        status_next         = ST_BUSY;
        freq_next           = '0;
        byte_next           = '0;

        if (halted_reg) begin
            status_next = ST_HALTED;
        end else if (s_stream_end) begin
            status_next         = mid_record_reg ? ST_END_PART : ST_END_CLEAN;
            in_token_phase_next = 1'b0;
            freq_accum_next     = '0;
            token_accum_next    = '0;
            tokens_seen_next    = '0;
            mid_record_next     = 1'b0;
        end else begin
            byte_next       = s_data_byte;
            mid_record_next = 1'b1;
            if (!in_token_phase_reg) begin
                // Frequency is checked after every byte, before it may end.
                if (freq_shift > FreqAccW'(max_freq_reg)) begin
                    status_next = ST_BIGFREQ;
                    halted_next = 1'b1;
                end else begin
                    freq_accum_next = freq_shift[FreqW-1:0];
                    if (last) begin
                        in_token_phase_next = 1'b1;
                    end
                end
            end else begin
                token_accum_next = tok_sat;
                if (last) begin
                    if (tok_sat >= vocab_size_reg) begin
                        status_next = ST_BADTOKEN;
                        halted_next = 1'b1;
                    end else begin
                        token_accum_next = '0;
                        tokens_seen_next = tokens_inc;
                        // A count register of zero completes after sixteen tokens.
                        if (tokens_inc == tokens_per_record_reg) begin
                            status_next         = ST_DONE;
                            freq_next           = freq_accum_reg;
                            in_token_phase_next = 1'b0;
                            freq_accum_next     = '0;
                            tokens_seen_next    = '0;
                            mid_record_next     = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Parser state advances only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_phase_reg <= 1'b0;
            freq_accum_reg     <= '0;
            token_accum_reg    <= '0;
            tokens_seen_reg    <= '0;
            mid_record_reg     <= 1'b0;
            halted_reg         <= 1'b0;
        end else if (in_acc) begin
            in_token_phase_reg <= in_token_phase_next;
            freq_accum_reg     <= freq_accum_next;
            token_accum_reg    <= token_accum_next;
            tokens_seen_reg    <= tokens_seen_next;
            mid_record_reg     <= mid_record_next;
            halted_reg         <= halted_next;
        end
    end

    // Output register.
    always_comb begin
        if (in_acc) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            status_reg <= status_next;
            freq_reg   <= freq_next;
            byte_reg   <= byte_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_freq     = freq_reg;
    assign m_byte_out = byte_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/nrvp_checker.sv =====
`default_nettype none

module nrvp_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_ready,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [nrvp_pkg::StatusW-1:0]      m_status,
    input wire [nrvp_pkg::FreqW-1:0]        m_freq,
    input wire [nrvp_pkg::ByteW-1:0]        m_byte_out
);
    import nrvp_pkg::*;

    // The output side is empty in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present right after reset");

    // A stalled result word holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_freq)
                                && $stable(m_byte_out))
        else $error("stalled result word changed");

    // Once an error or halt word is taken, the next word reports halted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_status == ST_BIGFREQ || m_status == ST_BADTOKEN
                               || m_status == ST_HALTED)
        |=> !m_valid || m_status == ST_HALTED)
        else $error("parser resumed after an error");

    // Frequency is reported only with a completed record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |-> m_freq == '0)
        else $error("frequency shown without record completion");

    // Stream end and halted words carry no byte, and while one is held s_ready follows m_ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_END_CLEAN || m_status == ST_END_PART
                    || m_status == ST_HALTED) |-> m_byte_out == '0 && s_ready == m_ready)
        else $error("byte passed through on a non-data word");

endmodule

bind ngram_record_varint_parser nrvp_checker u_nrvp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_freq     (m_freq),
    .m_byte_out (m_byte_out)
);

`default_nettype wire

// ===== tb/sv/tb_ngram_record_varint_parser.sv =====
`timescale 1ns / 1ps

module tb_ngram_record_varint_parser;
    import nrvp_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    // Index past the last register; writes to it must change nothing.
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        status_t           status;
        logic [FreqW-1:0]  freq;
        logic [ByteW-1:0]  byte_out;
    } parse_result_t;

    // Parser prediction plus the queue of results still owed by the block.
    class record_parse_checker;
        logic [CountW-1:0]   tokens_per_record;
        logic [TokenW-1:0]   vocab_size;
        logic [FreqW-1:0]    max_freq;
        bit                  in_token_phase;
        logic [FreqAccW-1:0] freq_accum;
        logic [TokenW-1:0]   token_accum;
        logic [CountW-1:0]   tokens_seen;
        bit                  mid_record;
        bit                  halted;
        parse_result_t       expected_results[$];
        int unsigned         errors;

        function new();
            tokens_per_record = RST_TOKENS_PER_RECORD;
            vocab_size = RST_VOCAB_SIZE;
            max_freq = RST_MAX_FREQ;
            clear_record();
            halted = 1'b0;
            errors = 0;
        endfunction

        function void clear_record();
            in_token_phase = 1'b0;
            freq_accum = '0;
            token_accum = '0;
            tokens_seen = '0;
            mid_record = 1'b0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
            case (idx)
                CFG_TOKENS_PER_RECORD: tokens_per_record = value[CountW-1:0];
                CFG_VOCAB_SIZE:        vocab_size = value[TokenW-1:0];
                CFG_MAX_FREQ:          max_freq = value[FreqW-1:0];
                default: ;
            endcase
        endfunction

        // Advance the parser by one accepted word and queue the result it owes.
        function void note_word(logic [ByteW-1:0] data, logic stream_end);
            parse_result_t r;
            logic [TokenW+GroupW-1:0] wide;
            r.status = ST_BUSY;
            r.freq = '0;
            r.byte_out = '0;
            if (halted) begin
                r.status = ST_HALTED;
            end else if (stream_end) begin
                r.status = mid_record ? ST_END_PART : ST_END_CLEAN;
                clear_record();
            end else begin
                r.byte_out = data;
                mid_record = 1'b1;
                if (!in_token_phase) begin
                    // The frequency limit applies after every group, final or not.
                    freq_accum = {freq_accum[FreqAccW-GroupW-1:0], data[GroupW-1:0]};
                    if (freq_accum > FreqAccW'(max_freq)) begin
                        r.status = ST_BIGFREQ;
                        halted = 1'b1;
                    end else if (!data[GroupW]) begin
                        in_token_phase = 1'b1;
                    end
                end else begin
                    // Token ids saturate at all ones instead of wrapping.
                    wide = {token_accum, data[GroupW-1:0]};
                    if (wide[TokenW+GroupW-1:TokenW] != '0) begin
                        token_accum = '1;
                    end else begin
                        token_accum = wide[TokenW-1:0];
                    end
                    if (!data[GroupW]) begin
                        if (token_accum >= vocab_size) begin
                            r.status = ST_BADTOKEN;
                            halted = 1'b1;
                        end else begin
                            token_accum = '0;
                            tokens_seen = tokens_seen + 1'b1;
                            if (tokens_seen == tokens_per_record) begin
                                r.status = ST_DONE;
                                r.freq = freq_accum[FreqW-1:0];
                                clear_record();
                            end
                        end
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [StatusW-1:0] status, logic [FreqW-1:0] freq,
                                   logic [ByteW-1:0] byte_out);
            parse_result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result word: status %0d freq %0d byte_out 0x%02h",
                       status, freq, byte_out);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (freq !== want.freq) begin
                $error("freq: expected %0d, actual %0d", want.freq, freq);
                errors++;
            end
            if (byte_out !== want.byte_out) begin
                $error("byte_out: expected 0x%02h, actual 0x%02h", want.byte_out, byte_out);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [ByteW-1:0]     s_data_byte;
    logic                 s_stream_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [StatusW-1:0]   m_status;
    logic [FreqW-1:0]     m_freq;
    logic [ByteW-1:0]     m_byte_out;
    logic                 cfg_wr_en;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CfgDataW-1:0]  cfg_wdata;

    record_parse_checker  sb;
    int unsigned          words_in = 0;
    int unsigned          cycle_count = 0;
    bit                   idle_on = 1'b1;
    logic [ByteW-1:0]     record_bytes[$];

    // Opening words: bit 8 marks a stream end, the low byte is the data.
    logic [ByteW:0] opening_words [0:24] = '{
        9'h1FF,                                 // clean end, data ignored
        9'h081, 9'h0FF, 9'h07F,                 // frequency 32767
        9'h08F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07E, // largest token id below the default vocab
        9'h000, 9'h000,                         // zero frequency, token zero
        9'h080, 9'h005, 9'h080, 9'h001,         // values with a leading zero group
        9'h003, 9'h0FF, 9'h100,                 // record cut off inside a token
        9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1AA // saturating token, cut off
    };

    ngram_record_varint_parser uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_stream_end (s_stream_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_freq       (m_freq),
        .m_byte_out   (m_byte_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CycleLimit);
        $display("ngram_record_varint_parser test failed");
        $finish;
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_word(s_data_byte, s_stream_end);
                words_in++;
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_status, m_freq, m_byte_out);
            end
        end
    end

    // The receiver stalls in random bursts while idling is allowed.
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Present one word at a falling edge and return at the falling edge after acceptance.
    task automatic send_word(input logic [ByteW-1:0] data, input logic stream_end);
        int unsigned gap;
        int unsigned seen;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_stream_end <= stream_end;
        seen = words_in;
        while (words_in == seen) @(negedge aclk);
    endtask

    // Hold off the sender until every owed result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(negedge aclk);
    endtask

    // Append a big-endian varint, sometimes with redundant leading zero groups.
    function automatic void push_varint(logic [TokenW-1:0] value);
        int groups;
        logic [TokenW-1:0] grp;
        groups = 1;
        while (groups < 5 && (value >> (GroupW * groups)) != 0) groups++;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) record_bytes.push_back(8'h80);
        end
        for (int i = groups - 1; i >= 0; i--) begin
            grp = value >> (GroupW * i);
            record_bytes.push_back({i != 0, grp[GroupW-1:0]});
        end
    endfunction

    // A value in [0, bound - 1] with the extremes and a spread of lengths.
    function automatic logic [TokenW-1:0] pick_below(logic [TokenW-1:0] bound);
        logic [TokenW-1:0] r;
        case ($urandom_range(0, 5))
            0: r = '0;
            1: r = bound - 1;
            default: begin
                r = $urandom;
                r = r >> $urandom_range(0, 31);
            end
        endcase
        if (r >= bound) r = r % bound;
        return r;
    endfunction

    function automatic logic [TokenW-1:0] pick_vocab();
        logic [TokenW-1:0] r;
        case ($urandom_range(0, 5))
            0: r = '1;
            1: r = '0;
            2: r = $urandom_range(1, 300);
            default: begin
                r = $urandom;
                r = r >> $urandom_range(0, 31);
            end
        endcase
        return r;
    endfunction

    // Mostly whole records with random content; the rest are bare stream ends
    // and records cut short by a stream end.
    task automatic send_record_stream(input int unsigned n_words);
        int unsigned sent;
        int unsigned ntok;
        int unsigned cut;
        bit cut_short;
        sent = 0;
        while (sent < n_words) begin
            record_bytes.delete();
            ntok = (sb.tokens_per_record == 0) ? 16 : sb.tokens_per_record;
            if ($urandom_range(0, 9) == 0) begin
                send_word(8'($urandom), 1'b1);
                sent++;
            end else begin
                push_varint(pick_below(TokenW'(sb.max_freq) + 1));
                if (sb.vocab_size == 0) begin
                    // No id is valid, so tokens never get their final group.
                    repeat ($urandom_range(1, 3)) record_bytes.push_back(8'h80 | 8'($urandom));
                end else begin
                    repeat (ntok) push_varint(pick_below(sb.vocab_size));
                end
                cut = record_bytes.size();
                cut_short = (sb.vocab_size == 0);
                if (!cut_short && $urandom_range(0, 7) == 0) begin
                    cut_short = 1'b1;
                    cut = $urandom_range(1, record_bytes.size() - 1);
                end
                for (int i = 0; i < cut; i++) begin
                    send_word(record_bytes[i], 1'b0);
                    sent++;
                end
                if (cut_short) begin
                    send_word(8'($urandom), 1'b1);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CountW-1:0] tpr, input logic [TokenW-1:0] vocab,
                             input logic [FreqW-1:0] maxf, input int unsigned n_words,
                             input bit idle);
        drain();
        write_reg(CFG_TOKENS_PER_RECORD, CfgDataW'(tpr));
        write_reg(CFG_VOCAB_SIZE, CfgDataW'(vocab));
        write_reg(CFG_MAX_FREQ, CfgDataW'(maxf));
        write_reg(CFG_UNUSED, $urandom);
        cfg_wr_en <= 1'b0;
        idle_on = idle;
        send_record_stream(n_words);
    endtask

    // Drive the parser into one of its error halts, then feed it halted words.
    task automatic provoke_halt();
        record_bytes.delete();
        case ($urandom_range(0, 2))
            0: begin
                // Continuation groups push the frequency past any limit.
                repeat (3) record_bytes.push_back(8'hFF);
            end
            1: begin
                record_bytes.push_back(8'h00);
                push_varint(sb.vocab_size);
            end
            default: begin
                // Token id overflows 32 bits and saturates.
                record_bytes.push_back(8'h00);
                repeat (5) record_bytes.push_back(8'hFF);
                record_bytes.push_back(8'h7F);
            end
        endcase
        foreach (record_bytes[i]) send_word(record_bytes[i], 1'b0);
        repeat (20) send_word(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    initial begin : stimulus
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = '0;
        s_stream_end = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words run on the reset values of the registers.
        foreach (opening_words[i]) send_word(opening_words[i][ByteW-1:0], opening_words[i][ByteW]);

        run_phase(4'd1, 32'hFFFF_FFFF, 15'h7FFF, 200, 1'b1);
        run_phase(4'd15, 32'd1, 15'd0, 150, 1'b1);
        run_phase(4'd0, pick_vocab(), 15'($urandom_range(0, 32767)), 250, 1'b0);
        run_phase(4'($urandom_range(1, 15)), 32'd0, 15'h7FFF, 100, 1'b1);
        run_phase(4'd2, 32'd128, 15'd127, 200, 1'b1);
        run_phase(4'($urandom_range(0, 15)), pick_vocab(), 15'($urandom_range(0, 32767)),
                  300, 1'b1);
        run_phase(4'($urandom_range(0, 15)), pick_vocab(), 15'($urandom_range(0, 32767)),
                  300, 1'b1);
        run_phase(4'($urandom_range(0, 15)), pick_vocab(), 15'($urandom_range(0, 32767)),
                  150, 1'b0);
        provoke_halt();

        drain();
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_results.size());
        end
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("ngram_record_varint_parser test passed");
        end else begin
            $display("ngram_record_varint_parser test failed");
        end
        $finish;
    end

endmodule
